// ===== design/mvsm_pkg.sv =====
// Shared types and constants for the multi-voice sample mixer.
package mvsm_pkg;
   localparam int VOICES = 32;
   localparam int SOUNDS = 64;
   localparam int SAMPLE_WORDS = 65536;
   localparam int VIDX_W = $clog2(VOICES);
   localparam int SIDX_W = $clog2(SOUNDS);
   localparam int SADDR_W = $clog2(SAMPLE_WORDS);
   localparam int SCNT_W = SIDX_W + 1;

   localparam logic [2:0] KIND_WRITE  = 3'd0;
   localparam logic [2:0] KIND_ADD    = 3'd1;
   localparam logic [2:0] KIND_PLAY   = 3'd2;
   localparam logic [2:0] KIND_STOP   = 3'd3;
   localparam logic [2:0] KIND_PAUSE  = 3'd4;
   localparam logic [2:0] KIND_VOL    = 3'd5;
   localparam logic [2:0] KIND_TICK   = 3'd6;
   localparam logic [2:0] KIND_UNUSED = 3'd7;

   localparam logic CSR_MASTER  = 1'b0;
   localparam logic CSR_EFFECTS = 1'b1;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] sample_address;
      logic [15:0] sample_value;
      logic [15:0] sound_base;
      logic [15:0] sound_frames;
      logic        sound_stereo;
      logic [6:0]  sound_sel;
      logic [15:0] voice_gain;
      logic [15:0] pan_value;
      logic [20:0] voice_ref;
      logic        pause_flag;
   } req_type;

   function automatic logic [16:0] cap_q15(input logic [15:0] g);
      cap_q15 = (g > 16'd32768) ? 17'd32768 : {1'b0, g};
   endfunction
endpackage

// ===== design/mvsm_ram.sv =====
// Generic single-port RAM with registered read.
module mvsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// ===== design/multi_voice_sample_mixer.sv =====
// Top level of the multi-voice sample mixer.
// One command item at a time; ready is high only in idle, and an item holds the
// block from acceptance until its result is taken. Write, add, stop, pause and
// the unused kind pass through idle, decode and result; set volume adds a voice
// read and write-back; play adds a scan of the voices for the first free one.
// Tick walks all 32 voices through one shared 18x18 multiplier: an inactive or
// paused voice is skipped, a voice at its end is freed, and a playing voice goes
// through voice read, math and sample read; a done state then saturates the mix.
// A stalled result holds the block in the result state. Memories are undefined
// until written; no clearing pass is needed.
module multi_voice_sample_mixer
   import mvsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind, sample_address, sample_value, sound_base, sound_frames, sound_stereo,
   // sound_sel, voice_gain, pan_value, voice_ref, pause_flag (low bit up)
   input  logic [135:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // left_out, right_out, handle_out, live_count (low bit up)
   output logic [63:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_CMD  = 8'b0000_0010,
      ST_VRD  = 8'b0000_0100,
      ST_VCHK = 8'b0000_1000,
      ST_MATH = 8'b0001_0000,
      ST_SRD  = 8'b0010_0000,
      ST_DONE = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   logic [15:0] master_ff, master_in, effects_ff, effects_in;
   logic [SCNT_W-1:0] scount_ff, scount_in;
   logic [VOICES-1:0] act_ff, act_in, pau_ff, pau_in;
   logic [15:0] gen_ff [VOICES];
   logic [15:0] gen_in [VOICES];
   logic [5:0]  last_ff, last_in;
   logic [VIDX_W:0] v_ff, v_in;
   logic [3:0]  step_ff, step_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic signed [47:0] accl_ff, accl_in, accr_ff, accr_in;
   logic [34:0] prod_ff, prod_in;
   logic [16:0] vol_ff, vol_in;
   logic [15:0] smpa_ff, smpa_in;
   logic [20:0] hout_ff, hout_in;
   logic signed [15:0] lo_ff, lo_in, ro_ff, ro_in;

   // shared multiplier: signed 18 x 18
   logic signed [17:0] ma, mb;
   logic signed [35:0] mp;
   assign mp = ma * mb;

   // sound table RAM: stereo, frames, base
   logic        snd_we;
   logic [SIDX_W-1:0] snd_addr;
   logic [32:0] snd_rd;
   mvsm_ram #(.WIDTH(33), .DEPTH(SOUNDS)) u_snd (
      .clock(clock), .we(snd_we), .addr(snd_addr),
      .wdata({req_ff.sound_stereo, req_ff.sound_frames, req_ff.sound_base}),
      .rdata(snd_rd));

   // voice RAM: sound, position, pan, gain
   logic        vc_we;
   logic [VIDX_W-1:0] vc_addr;
   logic [53:0] vc_wd, vc_rd;
   mvsm_ram #(.WIDTH(54), .DEPTH(VOICES)) u_voice (
      .clock(clock), .we(vc_we), .addr(vc_addr), .wdata(vc_wd), .rdata(vc_rd));

   logic        smp_we;
   logic [SADDR_W-1:0] smp_addr;
   logic [15:0] smp_rd;
   mvsm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_smp (
      .clock(clock), .we(smp_we), .addr(smp_addr),
      .wdata(req_ff.sample_value), .rdata(smp_rd));

   logic [VIDX_W-1:0] vi;
   logic [15:0] hgen;
   logic [4:0]  hidx_hi;
   logic        hmatch;
   logic [15:0] ngen;
   logic [15:0] pos;
   logic signed [16:0] pan17;
   logic signed [47:0] dl, dr;

   assign vi = v_ff[VIDX_W-1:0];
   assign hgen = req_ff.voice_ref[15:0];
   assign hidx_hi = req_ff.voice_ref[20:16];
   assign pos = vc_rd[47:32];
   assign pan17 = {vc_rd[31], vc_rd[31:16]};

   always_comb begin
      logic [VIDX_W-1:0] hv;
      hv = hidx_hi[VIDX_W-1:0];
      hmatch = (req_ff.voice_ref != 21'd0) && ({1'b0, hidx_hi} < 6'(VOICES)) &&
               (gen_ff[hv] == hgen);
   end
   assign ngen = (gen_ff[vi] == 16'hFFFF) ? 16'd1 : gen_ff[vi] + 16'd1;

   always_comb begin
      logic signed [47:0] sq;
      state_in = state_ff; req_in = req_ff;
      master_in = master_ff; effects_in = effects_ff;
      scount_in = scount_ff; act_in = act_ff; pau_in = pau_ff;
      gen_in = gen_ff; last_in = last_ff; v_in = v_ff; step_in = step_ff;
      cnt_in = cnt_ff; accl_in = accl_ff; accr_in = accr_ff; prod_in = prod_ff;
      vol_in = vol_ff; smpa_in = smpa_ff; hout_in = hout_ff;
      lo_in = lo_ff; ro_in = ro_ff;
      snd_we = 1'b0; snd_addr = req_ff.sound_sel[SIDX_W-1:0] - SIDX_W'(1);
      vc_we = 1'b0; vc_addr = vi; vc_wd = vc_rd;
      smp_we = 1'b0; smp_addr = req_ff.sample_address[SADDR_W-1:0];
      ma = '0; mb = '0; sq = '0; dl = '0; dr = '0;
      if (csr_we) begin
         if (csr_index == CSR_MASTER) master_in = csr_wdata;
         else effects_in = csr_wdata;
      end
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) begin
            req_in.kind = req_tdata[2:0];
            req_in.sample_address = req_tdata[18:3];
            req_in.sample_value = req_tdata[34:19];
            req_in.sound_base = req_tdata[50:35];
            req_in.sound_frames = req_tdata[66:51];
            req_in.sound_stereo = req_tdata[67];
            req_in.sound_sel = req_tdata[74:68];
            req_in.voice_gain = req_tdata[90:75];
            req_in.pan_value = req_tdata[106:91];
            req_in.voice_ref = req_tdata[127:107];
            req_in.pause_flag = req_tdata[128];
            hout_in = '0; lo_in = '0; ro_in = '0;
            v_in = '0; step_in = '0; cnt_in = '0; accl_in = '0; accr_in = '0;
            state_in = ST_CMD;
         end
         ST_CMD: begin
            state_in = ST_OUT;
            unique case (req_ff.kind)
               KIND_WRITE: smp_we = 1'b1;
               KIND_ADD: if (scount_ff < SCNT_W'(SOUNDS)) begin
                  snd_we = 1'b1; snd_addr = scount_ff[SIDX_W-1:0];
                  scount_in = scount_ff + SCNT_W'(1);
                  hout_in = 21'(scount_ff) + 21'd1;
               end
               KIND_PLAY: if (req_ff.sound_sel != 7'd0 &&
                              {1'b0, req_ff.sound_sel} <= 8'(scount_ff))
                  state_in = ST_VCHK;
               KIND_STOP: if (hmatch) act_in[hidx_hi[VIDX_W-1:0]] = 1'b0;
               KIND_PAUSE: if (hmatch)
                  pau_in[hidx_hi[VIDX_W-1:0]] = req_ff.pause_flag;
               KIND_VOL: if (hmatch) begin
                  vc_addr = hidx_hi[VIDX_W-1:0]; state_in = ST_VRD;
               end
               KIND_TICK: state_in = ST_VRD;
               default: ;
            endcase
         end
         ST_VCHK: begin
            // play: find first free voice
            if (v_ff == (VIDX_W+1)'(VOICES)) state_in = ST_OUT;
            else if (!act_ff[vi]) begin
               gen_in[vi] = ngen;
               act_in[vi] = 1'b1; pau_in[vi] = 1'b0;
               vc_we = 1'b1;
               vc_wd = {req_ff.sound_sel[SIDX_W-1:0] - SIDX_W'(1), 16'd0,
                        req_ff.pan_value, req_ff.voice_gain};
               hout_in = 21'({vi, ngen});
               state_in = ST_OUT;
            end else v_in = v_ff + 1'b1;
         end
         ST_VRD: begin
            // voice RAM data and sound descriptor become valid
            if (req_ff.kind == KIND_VOL) begin
               vc_addr = hidx_hi[VIDX_W-1:0];
               if (step_ff == 4'd1) begin
                  vc_we = 1'b1; vc_wd = {vc_rd[53:16], req_ff.voice_gain};
                  state_in = ST_OUT;
               end
               step_in = step_ff + 1'b1;
            end else if (v_ff == (VIDX_W+1)'(VOICES)) begin
               state_in = ST_DONE;
            end else if (!act_ff[vi] || pau_ff[vi]) begin
               v_in = v_ff + 1'b1;
            end else begin
               snd_addr = vc_rd[53:48];
               if (step_ff == 4'd1) begin
                  step_in = '0;
                  if (cnt_ff != 6'd63) cnt_in = cnt_ff + 6'd1;
                  state_in = ST_MATH;
               end else step_in = step_ff + 1'b1;
            end
         end
         ST_MATH: begin
            snd_addr = vc_rd[53:48];
            step_in = step_ff + 1'b1;
            case (step_ff)
               4'd0: if (pos >= snd_rd[31:16]) begin
                  act_in[vi] = 1'b0; v_in = v_ff + 1'b1; step_in = '0;
                  state_in = ST_VRD;
               end else begin
                  ma = 18'(cap_q15(vc_rd[15:0])); mb = 18'(cap_q15(master_ff));
                  prod_in = 35'(mp);
               end
               4'd1: begin
                  ma = 18'(prod_ff[31:15]); mb = 18'(cap_q15(effects_ff));
                  prod_in = 35'(mp);
               end
               4'd2: begin
                  vol_in = prod_ff[31:15];
                  ma = 18'({1'b0, prod_ff[31:15]});
                  mb = 18'sd32768 - 18'(pan17);
                  prod_in = 35'(mp);
               end
               4'd3: begin
                  vol_in = 17'(prod_ff[34:16] + 19'd16384); // left gain
                  ma = 18'({1'b0, vol_ff}); mb = 18'sd32768 + 18'(pan17);
                  prod_in = 35'(mp);
                  smpa_in = snd_rd[32] ? snd_rd[15:0] + {pos[14:0], 1'b0}
                                       : snd_rd[15:0] + pos;
                  state_in = ST_SRD;
               end
               default: ;
            endcase
         end
         ST_SRD: begin
            // steps 4..7: read left sample, multiply; read right, multiply
            step_in = step_ff + 1'b1;
            snd_addr = vc_rd[53:48];
            case (step_ff)
               4'd4: smp_addr = smpa_ff;
               4'd5: begin
                  smp_addr = smpa_ff;
                  ma = 18'(signed'(smp_rd)); mb = 18'({1'b0, vol_ff});
                  sq = 48'(mp); accl_in = accl_ff + sq;
                  vol_in = 17'(prod_ff[34:16] + 19'd16384); // right gain
                  smpa_in = snd_rd[32] ? smpa_ff + 16'd1 : smpa_ff;
               end
               4'd6: smp_addr = smpa_ff;
               default: begin
                  smp_addr = smpa_ff;
                  ma = 18'(signed'(smp_rd)); mb = 18'({1'b0, vol_ff});
                  sq = 48'(mp); accr_in = accr_ff + sq;
                  vc_we = 1'b1; vc_wd = {vc_rd[53:48], pos + 16'd1, vc_rd[31:0]};
                  v_in = v_ff + 1'b1; step_in = '0; state_in = ST_VRD;
               end
            endcase
         end
         ST_DONE: begin
            last_in = cnt_ff;
            dl = (accl_ff < 0) ? -((-accl_ff) >>> 15) : accl_ff >>> 15;
            dr = (accr_ff < 0) ? -((-accr_ff) >>> 15) : accr_ff >>> 15;
            lo_in = (dl > 48'sd32767) ? 16'sh7FFF : (dl < -48'sd32768) ? 16'sh8000
                    : 16'(dl);
            ro_in = (dr > 48'sd32767) ? 16'sh7FFF : (dr < -48'sd32768) ? 16'sh8000
                    : 16'(dr);
            state_in = ST_OUT;
         end
         ST_OUT: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; master_ff <= 16'd32768; effects_ff <= 16'd32768;
         scount_ff <= '0; act_ff <= '0; pau_ff <= '0; last_ff <= '0;
         for (int i = 0; i < VOICES; i++) gen_ff[i] <= '0;
      end else begin
         state_ff <= state_in; master_ff <= master_in; effects_ff <= effects_in;
         scount_ff <= scount_in; act_ff <= act_in; pau_ff <= pau_in;
         last_ff <= last_in; gen_ff <= gen_in;
      end
      req_ff <= req_in; v_ff <= v_in; step_ff <= step_in; cnt_ff <= cnt_in;
      accl_ff <= accl_in; accr_ff <= accr_in; prod_ff <= prod_in; vol_ff <= vol_in;
      smpa_ff <= smpa_in; hout_ff <= hout_in; lo_ff <= lo_in; ro_ff <= ro_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = {5'd0, last_ff, hout_ff, ro_ff, lo_ff};
endmodule

// ===== verif/tb_multi_voice_sample_mixer.sv =====
// Testbench for the multi-voice sample mixer: directed table, random commands, mix predictor.
`timescale 1ns / 100ps

module tb_multi_voice_sample_mixer
   import mvsm_pkg::*;
();

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] right;
      logic [20:0] handle;
      logic [5:0]  active;
   } mix_result_type;

   typedef struct {
      req_type        cmd;
      bit             typed;
      mix_result_type res;
   } table_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic         csr_we;
   logic         csr_index;
   logic [15:0]  csr_wdata;

   multi_voice_sample_mixer i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // mixer state as the predictor sees it
   logic [15:0] smem [0:SAMPLE_WORDS-1];
   bit          smem_written [0:SAMPLE_WORDS-1];
   logic [15:0] snd_base [0:SOUNDS-1];
   logic [15:0] snd_frames [0:SOUNDS-1];
   bit          snd_stereo [0:SOUNDS-1];
   int          snd_count;
   bit          v_active [0:VOICES-1];
   bit          v_paused [0:VOICES-1];
   logic [15:0] v_gen [0:VOICES-1];
   int          v_snd [0:VOICES-1];
   int          v_pos [0:VOICES-1];
   logic [15:0] v_gain [0:VOICES-1];
   logic [15:0] v_pan [0:VOICES-1];
   int          last_act;
   logic [15:0] master_gain;
   logic [15:0] effects_gain;

   mix_result_type frame_q [$];
   int          errors;
   int          sent;
   bit          send_burst;
   bit          recv_burst;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #50_000_000;
      $display("FAIL multi_voice_sample_mixer");
      $finish;
   end

   function automatic longint cap_gain(longint g);
      return (g > 32768) ? 32768 : g;
   endfunction

   function automatic logic [15:0] sat16(longint x);
      if (x > 32767) return 16'h7FFF;
      if (x < -32768) return 16'h8000;
      return x[15:0];
   endfunction

   function automatic logic [135:0] pack_cmd(req_type c);
      return {7'd0, c.pause_flag, c.voice_ref, c.pan_value, c.voice_gain, c.sound_sel,
              c.sound_stereo, c.sound_frames, c.sound_base, c.sample_value,
              c.sample_address, c.kind};
   endfunction

   function automatic int match_voice(logic [20:0] h);
      if (h == 0) return -1;
      if (v_gen[h[20:16]] != h[15:0]) return -1;
      return int'(h[20:16]);
   endfunction

   function automatic logic [15:0] read_addr(int v, bit right_ch);
      int s;
      logic [15:0] a;
      s = v_snd[v];
      if (snd_stereo[s]) begin
         a = snd_base[s] + 16'(2 * v_pos[v]);
         if (right_ch) a = a + 16'd1;
      end else begin
         a = snd_base[s] + 16'(v_pos[v]);
      end
      return a;
   endfunction

   // Mix one stereo frame; advances and frees voices.
   function automatic void mix_frame(output logic [15:0] l, output logic [15:0] r);
      longint acc_l, acc_r, vol, pan, lg, rg;
      int cnt;
      acc_l = 0;
      acc_r = 0;
      cnt = 0;
      for (int v = 0; v < VOICES; v++) begin
         if (!v_active[v] || v_paused[v]) continue;
         cnt++;
         if (v_pos[v] >= int'(snd_frames[v_snd[v]])) begin
            v_active[v] = 0;
            continue;
         end
         vol = (cap_gain(longint'(v_gain[v])) * cap_gain(longint'(master_gain))) >> 15;
         vol = (vol * cap_gain(longint'(effects_gain))) >> 15;
         pan = longint'($signed(v_pan[v]));
         lg = ((vol * (32768 - pan)) >> 16) + 16384;
         rg = ((vol * (32768 + pan)) >> 16) + 16384;
         acc_l += longint'($signed(smem[read_addr(v, 0)])) * lg;
         acc_r += longint'($signed(smem[read_addr(v, 1)])) * rg;
         v_pos[v]++;
      end
      last_act = (cnt > 63) ? 63 : cnt;
      l = sat16(acc_l / 32768);
      r = sat16(acc_r / 32768);
   endfunction

   function automatic mix_result_type apply_command(req_type c);
      mix_result_type res;
      int v;
      res = '0;
      case (c.kind)
         KIND_WRITE: begin
            smem[c.sample_address] = c.sample_value;
            smem_written[c.sample_address] = 1;
         end
         KIND_ADD: begin
            if (snd_count < SOUNDS) begin
               snd_base[snd_count] = c.sound_base;
               snd_frames[snd_count] = c.sound_frames;
               snd_stereo[snd_count] = c.sound_stereo;
               snd_count++;
               res.handle = 21'(snd_count);
            end
         end
         KIND_PLAY: begin
            if (c.sound_sel != 0 && int'(c.sound_sel) <= snd_count) begin
               for (v = 0; v < VOICES; v++) begin
                  if (!v_active[v]) begin
                     v_gen[v] = v_gen[v] + 16'd1;
                     if (v_gen[v] == 0) v_gen[v] = 16'd1;
                     v_snd[v] = int'(c.sound_sel) - 1;
                     v_pos[v] = 0;
                     v_gain[v] = c.voice_gain;
                     v_pan[v] = c.pan_value;
                     v_active[v] = 1;
                     v_paused[v] = 0;
                     res.handle = {5'(v), v_gen[v]};
                     break;
                  end
               end
            end
         end
         KIND_STOP: begin
            v = match_voice(c.voice_ref);
            if (v >= 0) v_active[v] = 0;
         end
         KIND_PAUSE: begin
            v = match_voice(c.voice_ref);
            if (v >= 0) v_paused[v] = c.pause_flag;
         end
         KIND_VOL: begin
            v = match_voice(c.voice_ref);
            if (v >= 0) v_gain[v] = c.voice_gain;
         end
         KIND_TICK: mix_frame(res.left, res.right);
         default: ;
      endcase
      res.active = 6'(last_act);
      return res;
   endfunction

   task automatic send_cmd(req_type c, bit typed, mix_result_type res);
      int gap;
      mix_result_type pred;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pack_cmd(c);
      do @(posedge clock); while (!req_tready);
      pred = apply_command(c);
      frame_q.push_back(typed ? res : pred);
      sent++;
   endtask

   task automatic write_csr(logic idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_MASTER) master_gain = val;
      else effects_gain = val;
   endtask

   task automatic drain();
      while (frame_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Write any sample word that the next tick would read but that holds no data yet.
   task automatic fill_tick_reads();
      req_type w;
      logic [15:0] a;
      for (int v = 0; v < VOICES; v++) begin
         if (!v_active[v] || v_paused[v] || v_pos[v] >= int'(snd_frames[v_snd[v]])) continue;
         for (int ch = 0; ch < 2; ch++) begin
            a = read_addr(v, ch[0]);
            if (!smem_written[a]) begin
               w = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
               w.kind = KIND_WRITE;
               w.sample_address = a;
               send_cmd(w, 0, '0);
            end
         end
      end
   endtask

   function automatic req_type random_cmd();
      req_type c;
      int r;
      int idx;
      c = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      r = $urandom_range(0, 99);
      if (r < 12) begin
         c.kind = KIND_WRITE;
         if ($urandom_range(0, 9) < 7) c.sample_address = 16'($urandom_range(0, 1023));
      end else if (r < 20) begin
         c.kind = KIND_ADD;
         if ($urandom_range(0, 9) < 7) c.sound_base = 16'($urandom_range(0, 1023));
         case ($urandom_range(0, 19))
            0: c.sound_frames = 16'hFFFF;
            1, 2: ;
            default: c.sound_frames = 16'($urandom_range(0, 12));
         endcase
      end else if (r < 36) begin
         c.kind = KIND_PLAY;
         if ($urandom_range(0, 9) < 8) c.sound_sel = 7'($urandom_range(1, snd_count + 1));
         if ($urandom_range(0, 1)) c.voice_gain = 16'($urandom_range(0, 32768));
      end else if (r < 60) begin
         c.kind = (r < 44) ? KIND_STOP : (r < 52) ? KIND_PAUSE : KIND_VOL;
         if ($urandom_range(0, 9) < 8) begin
            idx = $urandom_range(0, VOICES - 1);
            c.voice_ref = {5'(idx), v_gen[idx]};
         end
      end else if (r < 95) begin
         c.kind = KIND_TICK;
      end else if (r < 97) begin
         c.kind = KIND_UNUSED;
      end
      return c;
   endfunction

   always @(posedge clock) begin
      mix_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.left = rsp_tdata[15:0];
         got.right = rsp_tdata[31:16];
         got.handle = rsp_tdata[52:32];
         got.active = rsp_tdata[58:53];
         if (frame_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            want = frame_q.pop_front();
            if (got.left !== want.left)
               $display("%0t: left expected %h got %h", $time, want.left, got.left);
            if (got.right !== want.right)
               $display("%0t: right expected %h got %h", $time, want.right, got.right);
            if (got.handle !== want.handle)
               $display("%0t: handle expected %h got %h", $time, want.handle, got.handle);
            if (got.active !== want.active)
               $display("%0t: active expected %0d got %0d", $time, want.active, got.active);
            if (got !== want) errors++;
         end
      end
   end

   // Result side: random stalls plus one long hold-off that backs up the input.
   initial begin
      int stall;
      int taken;
      taken = 0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
         stall = recv_burst ? 0 : $urandom_range(0, 14);
         if (taken == 300) stall = 3000;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   initial begin
      table_row_type rows [22];
      logic [15:0] m_set [4];
      logic [15:0] e_set [4];
      req_type c;

      rows = '{
         '{'{KIND_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'd0, 1'b0},
           1, '{16'd0, 16'd0, 21'd0, 6'd0}},
         '{'{KIND_WRITE, 16'd0, 16'h7FFF, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'd0, 1'b0},
           1, '{16'd0, 16'd0, 21'd0, 6'd0}},
         '{'{KIND_WRITE, 16'd1, 16'h8000, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'd0, 1'b0},
           1, '{16'd0, 16'd0, 21'd0, 6'd0}},
         '{'{KIND_WRITE, 16'hFFFF, 16'd1234, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'd0, 1'b0},
           1, '{16'd0, 16'd0, 21'd0, 6'd0}},
         '{'{KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 7'h7F, 16'hFFFF,
             16'hFFFF, 21'h1FFFFF, 1'b1}, 1, '{16'd0, 16'd0, 21'd0, 6'd0}},
         // stereo sound, wrapping mono sound, empty sound
         '{'{KIND_ADD, 16'd0, 16'd0, 16'd0, 16'd1, 1'b1, 7'd0, 16'd0, 16'd0, 21'd0, 1'b0},
           1, '{16'd0, 16'd0, 21'd1, 6'd0}},
         '{'{KIND_ADD, 16'd0, 16'd0, 16'hFFFF, 16'd2, 1'b0, 7'd0, 16'd0, 16'd0, 21'd0, 1'b0},
           1, '{16'd0, 16'd0, 21'd2, 6'd0}},
         '{'{KIND_ADD, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'd0, 1'b0},
           1, '{16'd0, 16'd0, 21'd3, 6'd0}},
         '{'{KIND_PLAY, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'd0, 1'b0},
           1, '{16'd0, 16'd0, 21'd0, 6'd0}},
         '{'{KIND_PLAY, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd4, 16'd0, 16'd0, 21'd0, 1'b0},
           1, '{16'd0, 16'd0, 21'd0, 6'd0}},
         '{'{KIND_PLAY, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd1, 16'd32768, 16'h8000, 21'd0,
             1'b0}, 1, '{16'd0, 16'd0, 21'h00001, 6'd0}},
         '{'{KIND_PLAY, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd2, 16'hFFFF, 16'h7FFF, 21'd0,
             1'b0}, 1, '{16'd0, 16'd0, 21'h10001, 6'd0}},
         '{'{KIND_PLAY, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd3, 16'd0, 16'd0, 21'd0, 1'b0},
           1, '{16'd0, 16'd0, 21'h20001, 6'd0}},
         '{'{KIND_PAUSE, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'h10001, 1'b1},
           0, '0},
         '{'{KIND_VOL, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd16384, 16'd0, 21'h00001,
             1'b0}, 0, '0},
         '{'{KIND_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'd0, 1'b0}, 0, '0},
         '{'{KIND_PAUSE, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'h10001, 1'b0},
           0, '0},
         // stale generation: must be ignored
         '{'{KIND_STOP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'h00002, 1'b0},
           0, '0},
         '{'{KIND_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'd0, 1'b0}, 0, '0},
         '{'{KIND_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'd0, 1'b0}, 0, '0},
         '{'{KIND_STOP, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'h1FFFFF, 1'b0},
           0, '0},
         '{'{KIND_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 7'd0, 16'd0, 16'd0, 21'd0, 1'b0}, 0, '0}
      };
      m_set = '{16'd32768, 16'd0, 16'hFFFF, 16'($urandom)};
      e_set = '{16'd32768, 16'hFFFF, 16'd16384, 16'($urandom)};

      errors = 0;
      sent = 0;
      send_burst = 0;
      recv_burst = 0;
      snd_count = 0;
      last_act = 0;
      master_gain = 16'd32768;
      effects_gain = 16'd32768;
      for (int v = 0; v < VOICES; v++) begin
         v_active[v] = 0;
         v_paused[v] = 0;
         v_gen[v] = 16'd0;
         v_snd[v] = 0;
         v_pos[v] = 0;
         v_gain[v] = 16'd0;
         v_pan[v] = 16'd0;
      end
      for (int a = 0; a < SAMPLE_WORDS; a++) smem_written[a] = 0;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = CSR_MASTER;
      csr_wdata = 16'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 4; p++) begin
         write_csr(CSR_MASTER, m_set[p]);
         write_csr(CSR_EFFECTS, e_set[p]);
         csr_we <= 1'b0;
         if (p == 0) begin
            foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].res);
         end
         // sample fills count toward the item total
         while (sent < 22 + (p + 1) * 232) begin
            c = random_cmd();
            if (c.kind == KIND_TICK) fill_tick_reads();
            send_cmd(c, 0, '0);
         end
         req_tvalid <= 1'b0;
         drain();
      end

      if (errors == 0) begin
         $display("PASS multi_voice_sample_mixer");
      end else begin
         $display("FAIL multi_voice_sample_mixer");
      end
      $finish;
   end
endmodule
